@@ rtl/pst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types, codes and the watched service port table of the port scan
// host tracker.
// ----------------------------------------------------------------------------
package pst_pkg;

   // Defaults and upper bounds of the top-level parameters
   localparam int DEF_NUM_WATCHED_PORTS = 20;
   localparam int DEF_HOSTS_PER_PORT    = 16;
   localparam int MAX_WATCHED_PORTS     = 64;
   localparam int MAX_HOSTS_PER_PORT    = 256;

   // Field widths of the request and response words
   localparam int ADDR_W   = 32;
   localparam int PORT_W   = 16;
   localparam int STAMP_W  = 32;
   localparam int STATUS_W = 3;
   localparam int OSLOT_W  = 5;
   localparam int OSEEN_W  = 5;

   // Token fields sized for the largest configuration
   localparam int PST_SLOT_W  = $clog2(MAX_WATCHED_PORTS);
   localparam int PST_COUNT_W = $clog2(MAX_HOSTS_PER_PORT + 1);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_NOT_WATCHED = 3'd0,
      STATUS_SEEN        = 3'd1,
      STATUS_RECORDED    = 3'd2,
      STATUS_FULL        = 3'd3,
      STATUS_CLEARED     = 3'd4
   } pst_status_type;

   typedef enum logic {
      KIND_PACKET = 1'b0,
      KIND_CLEAR  = 1'b1
   } pst_kind_type;

   // Lookup word that walks down the row of host cells
   typedef struct packed {
      logic                   valid;
      logic                   found;
      logic [PST_SLOT_W-1:0]  slot;
      logic [PST_COUNT_W-1:0] count;
      logic [ADDR_W-1:0]      addr;
      logic [STAMP_W-1:0]     stamp;
   } pst_token_type;

   localparam int PST_PORT_TABLE_LEN = 20;

   localparam logic [PORT_W-1:0] PST_PORT_TABLE [PST_PORT_TABLE_LEN] = '{
      16'd7,   16'd9,   16'd20,  16'd21,  16'd23,
      16'd25,  16'd53,  16'd69,  16'd79,  16'd111,
      16'd123, 16'd161, 16'd162, 16'd512, 16'd513,
      16'd514, 16'd515, 16'd520, 16'd540, 16'd6000
   };

endpackage

@@ rtl/pst_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_req_if
// Request channel: packet or clear words with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pst_req_if;
   import pst_pkg::*;

   logic               valid;
   logic               ready;
   logic               kind;
   logic [ADDR_W-1:0]  source_addr;
   logic [PORT_W-1:0]  dest_port;
   logic [STAMP_W-1:0] timestamp;

   modport source (
      output valid, kind, source_addr, dest_port, timestamp,
      input  ready
   );

   modport sink (
      input  valid, kind, source_addr, dest_port, timestamp,
      output ready
   );

endinterface

@@ rtl/pst_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_rsp_if
// Response channel: one status word per request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pst_rsp_if;
   import pst_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [OSLOT_W-1:0]  port_slot;
   logic [OSEEN_W-1:0]  hosts_seen;

   modport source (
      output valid, status, port_slot, hosts_seen,
      input  ready
   );

   modport sink (
      input  valid, status, port_slot, hosts_seen,
      output ready
   );

endinterface

@@ rtl/pst_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_cell
// One host position of every watched port: compares the passing lookup word
// with its stored address and appends the address when it is the next free
// position.
// ----------------------------------------------------------------------------
module pst_cell #(
   parameter int NUM_WATCHED_PORTS = pst_pkg::DEF_NUM_WATCHED_PORTS,
   parameter int CELL_INDEX        = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pst_pkg::pst_token_type token_in,
   output pst_pkg::pst_token_type token_out
);
   import pst_pkg::*;

   localparam int SLOT_IDX_W = (NUM_WATCHED_PORTS > 1) ? $clog2(NUM_WATCHED_PORTS) : 1;
   localparam logic [PST_COUNT_W-1:0] CELL_POS = PST_COUNT_W'(CELL_INDEX);

   logic [ADDR_W-1:0]  addr_mem [NUM_WATCHED_PORTS];
   logic [STAMP_W-1:0] time_mem [NUM_WATCHED_PORTS];

   pst_token_type      token_ff;
   logic [ADDR_W-1:0]  rd_addr_ff;
   logic [SLOT_IDX_W-1:0] rd_idx;
   logic [SLOT_IDX_W-1:0] wr_idx;
   logic               hit;
   logic               wr_en;

   assign rd_idx = token_in.slot[SLOT_IDX_W-1:0];
   assign wr_idx = token_ff.slot[SLOT_IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff.valid <= 1'b0;
      end else begin
         token_ff <= token_in;
      end
   end

   // read the entry for the arriving word's port alongside the word itself
   always_ff @(posedge clock) begin
      rd_addr_ff <= addr_mem[rd_idx];
   end

   // only positions below the port's fill count hold live hosts
   assign hit = token_ff.valid && (CELL_POS < token_ff.count) && (rd_addr_ff == token_ff.addr);

   // append here when all live positions missed and this is the next free one
   assign wr_en = token_ff.valid && !token_ff.found && (token_ff.count == CELL_POS);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         addr_mem[wr_idx] <= token_ff.addr;
         time_mem[wr_idx] <= token_ff.stamp;
      end
   end

   always_comb begin
      token_out       = token_ff;
      token_out.found = token_ff.found | hit;
   end

endmodule

@@ rtl/port_scan_host_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_scan_host_tracker
// Records distinct source addresses per watched service port and reports
// whether each packet's host is new, already seen, dropped on a full set or sent to an unwatched port.
//
//   channel   direction  handshake      payload
//   req_if    in         valid/ready    kind, source_addr, dest_port, timestamp
//   rsp_if    out        valid/ready    status, port_slot, hosts_seen
//
// A packet to a watched port is registered as a lookup word that passes one
// host cell per cycle down the row before its response is loaded.
// Clear and unwatched-port words skip the row. One word is in flight at a
// time; req_if.ready is high only while the block is idle, so a new word is
// taken only after the last one's response is loaded.
// Reset is synchronous and empties every host set at once.
// A response held by a stalled sink holds the next word's result, which
// delays acceptance of the word after it.
// ----------------------------------------------------------------------------
module port_scan_host_tracker #(
   parameter int NUM_WATCHED_PORTS = pst_pkg::DEF_NUM_WATCHED_PORTS,
   parameter int HOSTS_PER_PORT    = pst_pkg::DEF_HOSTS_PER_PORT
) (
   input  logic       clock,
   input  logic       reset,
   pst_req_if.sink    req_if,
   pst_rsp_if.source  rsp_if
);
   import pst_pkg::*;

   localparam int SLOT_IDX_W = (NUM_WATCHED_PORTS > 1) ? $clog2(NUM_WATCHED_PORTS) : 1;
   localparam int CNT_W      = $clog2(HOSTS_PER_PORT + 1);
   localparam int LOOKUP_N   = (NUM_WATCHED_PORTS < PST_PORT_TABLE_LEN) ?
                               NUM_WATCHED_PORTS : PST_PORT_TABLE_LEN;
   localparam logic [PST_COUNT_W-1:0] FULL_COUNT = PST_COUNT_W'(HOSTS_PER_PORT);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_RESULT
   } state_type;

   state_type           state_ff, state_in;
   pst_token_type       launch_ff, launch_in;
   pst_status_type      pend_status_ff, pend_status_in;
   logic [OSLOT_W-1:0]  pend_slot_ff, pend_slot_in;
   logic [OSEEN_W-1:0]  pend_seen_ff, pend_seen_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [OSLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [OSEEN_W-1:0]  rsp_seen_ff, rsp_seen_in;

   logic [CNT_W-1:0]    count_ff [NUM_WATCHED_PORTS];
   logic                clear_all;
   logic                count_wr;
   logic [CNT_W-1:0]    count_wr_val;
   logic [SLOT_IDX_W-1:0] count_wr_idx;

   logic                port_hit;
   logic [SLOT_IDX_W-1:0] port_idx;
   logic [PST_COUNT_W-1:0] next_count;

   pst_token_type       chain [HOSTS_PER_PORT+1];
   logic [HOSTS_PER_PORT:0] chain_valid;
   pst_token_type       walk_out;

   // watched port lookup, lowest table position wins
   always_comb begin
      port_hit = 1'b0;
      port_idx = '0;
      for (int i = LOOKUP_N - 1; i >= 0; i--) begin
         if (PST_PORT_TABLE[i] == req_if.dest_port) begin
            port_hit = 1'b1;
            port_idx = SLOT_IDX_W'(i);
         end
      end
   end

   // row of host cells
   assign chain[0] = launch_ff;

   for (genvar g = 0; g < HOSTS_PER_PORT; g++) begin : g_cell
      pst_cell #(
         .NUM_WATCHED_PORTS (NUM_WATCHED_PORTS),
         .CELL_INDEX        (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .token_in  (chain[g]),
         .token_out (chain[g+1])
      );
   end

   for (genvar v = 0; v <= HOSTS_PER_PORT; v++) begin : g_valid
      assign chain_valid[v] = chain[v].valid;
   end

   assign walk_out   = chain[HOSTS_PER_PORT];
   assign next_count = walk_out.count + PST_COUNT_W'(1);

   always_comb begin
      state_in       = state_ff;
      launch_in      = launch_ff;
      launch_in.valid = 1'b0;
      pend_status_in = pend_status_ff;
      pend_slot_in   = pend_slot_ff;
      pend_seen_in   = pend_seen_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_seen_in    = rsp_seen_ff;
      clear_all      = 1'b0;
      count_wr       = 1'b0;
      count_wr_val   = '0;
      count_wr_idx   = walk_out.slot[SLOT_IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               if (req_if.kind == KIND_CLEAR) begin
                  clear_all      = 1'b1;
                  pend_status_in = STATUS_CLEARED;
                  pend_slot_in   = '0;
                  pend_seen_in   = '0;
                  state_in       = ST_RESULT;
               end else if (port_hit) begin
                  launch_in.valid = 1'b1;
                  launch_in.found = 1'b0;
                  launch_in.slot  = PST_SLOT_W'(port_idx);
                  launch_in.count = PST_COUNT_W'(count_ff[port_idx]);
                  launch_in.addr  = req_if.source_addr;
                  launch_in.stamp = req_if.timestamp;
                  state_in        = ST_WALK;
               end else begin
                  pend_status_in = STATUS_NOT_WATCHED;
                  pend_slot_in   = '0;
                  pend_seen_in   = '0;
                  state_in       = ST_RESULT;
               end
            end
         end
         ST_WALK: begin
            if (walk_out.valid) begin
               pend_slot_in = walk_out.slot[OSLOT_W-1:0];
               pend_seen_in = walk_out.count[OSEEN_W-1:0];
               if (walk_out.found) begin
                  pend_status_in = STATUS_SEEN;
               end else if (walk_out.count == FULL_COUNT) begin
                  pend_status_in = STATUS_FULL;
               end else begin
                  // the cell at the fill position has stored the host
                  pend_status_in = STATUS_RECORDED;
                  pend_seen_in   = next_count[OSEEN_W-1:0];
                  count_wr       = 1'b1;
                  count_wr_val   = next_count[CNT_W-1:0];
               end
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_slot_in   = pend_slot_ff;
               rsp_seen_in   = pend_seen_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         launch_ff.valid <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         launch_ff      <= launch_in;
         pend_status_ff <= pend_status_in;
         pend_slot_ff   <= pend_slot_in;
         pend_seen_ff   <= pend_seen_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_slot_ff    <= rsp_slot_in;
         rsp_seen_ff    <= rsp_seen_in;
      end
   end

   // per-port fill counts
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         for (int p = 0; p < NUM_WATCHED_PORTS; p++) begin
            count_ff[p] <= '0;
         end
      end else if (count_wr) begin
         count_ff[count_wr_idx] <= count_wr_val;
      end
   end

   assign req_if.ready      = (state_ff == ST_IDLE);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.port_slot  = rsp_slot_ff;
   assign rsp_if.hosts_seen = rsp_seen_ff;

   // at most one lookup word in the row
   a_single_word: assert property (@(posedge clock) disable iff (reset)
      $countones(chain_valid) <= 1)
      else $error("more than one lookup word in the host cell row");

   // a word leaves the row only while a walk is pending
   a_walk_exit: assert property (@(posedge clock) disable iff (reset)
      walk_out.valid |-> state_ff == ST_WALK)
      else $error("lookup word left the row outside a walk");

   // a launched fill count never exceeds the set size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      launch_ff.valid |-> launch_ff.count <= FULL_COUNT)
      else $error("fill count beyond set size");

   // an accepted clear word is answered with the cleared status
   a_clear_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.kind == KIND_CLEAR)
      |=> (state_ff == ST_RESULT && pend_status_ff == STATUS_CLEARED))
      else $error("clear word not answered as cleared");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for port_scan_host_tracker. Packet and clear words go
// in over the request channel with random gaps. Every response word is
// compared field by field with the outcome forecast by a behavioural copy of
// the per-port host sets. A short directed sequence covers unwatched ports,
// new and repeated hosts, clearing and a full set. Random traffic follows,
// drawn from a small address pool so that sets fill and overflow.
// ----------------------------------------------------------------------------
module testbench;
   import pst_pkg::*;

   localparam int NUM_SLOTS    = DEF_NUM_WATCHED_PORTS;
   localparam int SET_DEPTH    = DEF_HOSTS_PER_PORT;
   localparam int POOL_SIZE    = 24;
   localparam int DRAIN_CYCLES = 2 * (SET_DEPTH + 3);
   localparam int CYCLE_LIMIT  = 400000;

   localparam logic [PORT_W-1:0] SERVICE_PORTS [NUM_SLOTS] = '{
      16'd7,   16'd9,   16'd20,  16'd21,  16'd23,
      16'd25,  16'd53,  16'd69,  16'd79,  16'd111,
      16'd123, 16'd161, 16'd162, 16'd512, 16'd513,
      16'd514, 16'd515, 16'd520, 16'd540, 16'd6000
   };

   typedef struct {
      pst_status_type     status;
      logic [OSLOT_W-1:0] slot;
      logic [OSEEN_W-1:0] seen;
   } verdict_type;

   logic clock;
   logic reset;

   pst_req_if req_ch ();
   pst_rsp_if rsp_ch ();

   port_scan_host_tracker #(
      .NUM_WATCHED_PORTS (NUM_SLOTS),
      .HOSTS_PER_PORT    (SET_DEPTH)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Forecast state: the host addresses recorded per watched port
   logic [ADDR_W-1:0] host_addrs [NUM_SLOTS][SET_DEPTH];
   int                host_tally [NUM_SLOTS];

   verdict_type pending_verdicts [$];
   int       error_count;
   int       words_sent;
   int       cycle_count;
   int       status_tally [5];
   int       req_idle_level;
   int       rsp_idle_level;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic verdict_type predict_verdict(input pst_kind_type kind,
                                                   input logic [ADDR_W-1:0] addr,
                                                   input logic [PORT_W-1:0] port);
      verdict_type v;
      int       slot;
      int       fill;
      int       i;
      v    = '{status: STATUS_NOT_WATCHED, slot: '0, seen: '0};
      slot = -1;
      if (kind == KIND_CLEAR) begin
         foreach (host_tally[j]) host_tally[j] = 0;
         v.status = STATUS_CLEARED;
         return v;
      end
      for (i = 0; i < NUM_SLOTS; i++) begin
         if (slot < 0 && SERVICE_PORTS[i] == port) slot = i;
      end
      if (slot < 0) return v;
      fill   = host_tally[slot];
      v.slot = OSLOT_W'(slot);
      v.seen = OSEEN_W'(fill);
      for (i = 0; i < fill; i++) begin
         if (host_addrs[slot][i] == addr) begin
            v.status = STATUS_SEEN;
            return v;
         end
      end
      if (fill >= SET_DEPTH) begin
         v.status = STATUS_FULL;
         return v;
      end
      host_addrs[slot][fill] = addr;
      host_tally[slot]       = fill + 1;
      v.status = STATUS_RECORDED;
      v.seen   = OSEEN_W'(fill + 1);
      return v;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap(input int level);
      int r;
      r = $urandom_range(0, 99);
      if (level == 0) return 0;
      if (level == 1) begin
         if (r < 65) return 0;
         if (r < 92) return $urandom_range(1, 3);
         return $urandom_range(8, 40);
      end
      if (r < 30) return 0;
      if (r < 70) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_word(input pst_kind_type kind, input logic [ADDR_W-1:0] addr,
                            input logic [PORT_W-1:0] port,
                            input logic [STAMP_W-1:0] stamp);
      int gap;
      gap = pick_gap(req_idle_level);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= kind;
      req_ch.source_addr <= addr;
      req_ch.dest_port   <= port;
      req_ch.timestamp   <= stamp;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      pending_verdicts.push_back(predict_verdict(kind, addr, port));
      words_sent++;
   endtask

   // Response side: random back-pressure and a field-by-field comparison
   initial begin : response_checker
      int       stall_left;
      verdict_type v;
      stall_left   = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (rsp_ch.status < 5) status_tally[rsp_ch.status]++;
            if (pending_verdicts.size() == 0) begin
               $display("%0t: response word with nothing outstanding (status %0d)",
                        $time, rsp_ch.status);
               error_count++;
            end else begin
               v = pending_verdicts.pop_front();
               if (rsp_ch.status !== v.status) begin
                  $display("%0t: status expected %0d (%s), actual %0d", $time,
                           v.status, v.status.name(), rsp_ch.status);
                  error_count++;
               end
               if (rsp_ch.port_slot !== v.slot) begin
                  $display("%0t: port_slot expected %0d, actual %0d", $time,
                           v.slot, rsp_ch.port_slot);
                  error_count++;
               end
               if (rsp_ch.hosts_seen !== v.seen) begin
                  $display("%0t: hosts_seen expected %0d, actual %0d", $time,
                           v.seen, rsp_ch.hosts_seen);
                  error_count++;
               end
            end
         end
         rsp_ch.ready <= (stall_left == 0);
         if (stall_left > 0) begin
            stall_left--;
         end else if (rsp_idle_level != 0 &&
                      $urandom_range(0, 99) < (rsp_idle_level == 1 ? 20 : 50)) begin
            stall_left = pick_gap(rsp_idle_level);
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("** port_scan_host_tracker: FAILED **");
      $finish;
   end

   task automatic test_unwatched_ports();
      send_word(KIND_PACKET, 32'h0000_0000, 16'd0, 32'h0000_0000);
      send_word(KIND_PACKET, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      // neighbour of two watched ports
      send_word(KIND_PACKET, 32'h0A00_0001, 16'd8, 32'd1000);
   endtask

   task automatic test_record_and_repeat();
      send_word(KIND_PACKET, 32'h0000_0000, 16'd7, 32'd10);
      send_word(KIND_PACKET, 32'h0000_0000, 16'd7, 32'd11);
      send_word(KIND_PACKET, 32'hFFFF_FFFF, 16'd6000, 32'hFFFF_FFFF);
      send_word(KIND_PACKET, 32'hFFFF_FFFF, 16'd7, 32'd0);
   endtask

   task automatic test_clear();
      // fields of a clear word carry no meaning; fill address and timestamp with noise
      send_word(KIND_CLEAR, $urandom, 16'd7, $urandom);
      send_word(KIND_PACKET, 32'h0000_0000, 16'd7, 32'd12);
   endtask

   task automatic test_set_full();
      int i;
      for (i = 0; i <= SET_DEPTH; i++)
         send_word(KIND_PACKET, 32'hC0A8_0100 + i, 16'd111, 32'd500 + i);
      send_word(KIND_PACKET, 32'hC0A8_0105, 16'd111, 32'd600);
   endtask

   task automatic run_random_phase(input int n_words, input int req_level,
                                   input int rsp_level);
      logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
      int                hot_slot [3];
      int                pick;
      logic [ADDR_W-1:0] addr;
      req_idle_level = req_level;
      rsp_idle_level = rsp_level;
      foreach (addr_pool[i]) addr_pool[i] = $urandom;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      foreach (hot_slot[i]) hot_slot[i] = $urandom_range(0, NUM_SLOTS - 1);
      repeat (n_words) begin
         pick = $urandom_range(0, 99);
         addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
         if (pick < 3)
            send_word(KIND_CLEAR, $urandom, PORT_W'($urandom), $urandom);
         else if (pick < 13)
            send_word(KIND_PACKET, $urandom, PORT_W'($urandom_range(0, 16'hFFFF)),
                      $urandom);
         else if (pick < 18)
            send_word(KIND_PACKET, $urandom,
                      SERVICE_PORTS[$urandom_range(0, NUM_SLOTS - 1)], $urandom);
         else if (pick < 33)
            send_word(KIND_PACKET, addr,
                      SERVICE_PORTS[$urandom_range(0, NUM_SLOTS - 1)], $urandom);
         else
            send_word(KIND_PACKET, addr, SERVICE_PORTS[hot_slot[$urandom_range(0, 2)]],
                      $urandom);
      end
   endtask

   task automatic test_back_to_back();
      run_random_phase(100, 0, 0);
   endtask

   task automatic test_mixed_idling();
      run_random_phase(300, 1, 1);
   endtask

   task automatic test_heavy_stalls();
      run_random_phase(100, 2, 2);
   endtask

   initial begin
      error_count    = 0;
      words_sent     = 0;
      req_idle_level = 1;
      rsp_idle_level = 1;
      foreach (host_tally[i]) host_tally[i] = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.kind        <= KIND_PACKET;
      req_ch.source_addr <= '0;
      req_ch.dest_port   <= '0;
      req_ch.timestamp   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_unwatched_ports();
      test_record_and_repeat();
      test_clear();
      test_set_full();
      test_back_to_back();
      test_mixed_idling();
      test_heavy_stalls();

      req_ch.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d words in %0d cycles with varied gaps and back-pressure.",
               words_sent, cycle_count);
      $display("Responses: %0d unwatched, %0d seen, %0d recorded, %0d full, %0d cleared.",
               status_tally[STATUS_NOT_WATCHED], status_tally[STATUS_SEEN],
               status_tally[STATUS_RECORDED], status_tally[STATUS_FULL],
               status_tally[STATUS_CLEARED]);
      if (error_count == 0) begin
         $display("** port_scan_host_tracker: PASSED **");
      end else begin
         $display("** port_scan_host_tracker: FAILED **");
      end
      $finish;
   end

endmodule

@@ port_scan_host_tracker.f @@
rtl/pst_pkg.sv
rtl/pst_req_if.sv
rtl/pst_rsp_if.sv
rtl/pst_cell.sv
rtl/port_scan_host_tracker.sv
tb/testbench.sv
